### rtl/gwbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the clock-replacement cache controller.
package gwbc_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int REQ_W     = 3;
  localparam int ADDR_W    = 32;
  localparam int ACT_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 8;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;
  localparam logic [CNT_W-1:0] LIMIT_RST = 8'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ        = 3'd0,
    REQ_WRITE       = 3'd1,
    REQ_FLUSH       = 3'd2,
    REQ_CLR_WB      = 3'd3,
    REQ_CLR_DISCARD = 3'd4
  } req_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_SERVE = 2'd0,
    ACT_WB    = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_DONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM,
    ST_MISS,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_FLUSH,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    ptr_inc;
    logic    take_hit;
    logic    sweep;
    logic    take_victim;
    logic    install;
    logic    touch;
    logic    clear_all;
    logic    use_slot;
    logic    emit;
    action_t act;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic ptr_last;
    logic victim_ok;
    logic slot_dirty;
    logic flush_hit;
    logic out_free;
    logic is_read;
    logic clr_wb;
  } sts_t;

endpackage

### rtl/gwbc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the cache controller: search, victim sweep, write-back, fill, serve, flush and clear.
module gwbc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic [gwbc_pkg::REQ_W-1:0]   in_req,
  output logic                         in_tready,
  input  gwbc_pkg::sts_t               sts,
  output gwbc_pkg::cmd_t               cmd
);
  import gwbc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.act   = ACT_SERVE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (in_req) inside
            REQ_READ, REQ_WRITE:  state_nxt = ST_SCAN;
            REQ_FLUSH, REQ_CLR_WB: state_nxt = ST_FLUSH;
            REQ_CLR_DISCARD:       state_nxt = ST_CLEAR;
            default:               state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_ACCESS;
        end else if (sts.ptr_last) begin
          state_nxt = ST_VICTIM;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_VICTIM: begin
        if (sts.victim_ok) begin
          cmd.take_victim = 1'b1;
          state_nxt       = ST_MISS;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      ST_MISS: begin
        if (sts.slot_dirty) begin
          state_nxt = ST_WB;
        end else begin
          cmd.install = 1'b1;
          state_nxt   = sts.is_read ? ST_FILL : ST_ACCESS;
        end
      end
      ST_WB: begin
        cmd.use_slot = 1'b1;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.act     = ACT_WB;
          cmd.install = 1'b1;
          state_nxt   = sts.is_read ? ST_FILL : ST_ACCESS;
        end
      end
      ST_FILL: begin
        cmd.use_slot = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_FILL;
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.use_slot = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_SERVE;
          cmd.last  = 1'b1;
          cmd.touch = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!sts.flush_hit || sts.out_free) begin
          cmd.emit = sts.flush_hit;
          cmd.act  = ACT_WB;
          if (sts.ptr_last) begin
            state_nxt = sts.clr_wb ? ST_CLEAR : ST_DONE;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear_all = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_DONE;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/gwbc_dp.sv
`timescale 1ns / 1ps
// Datapath of the cache controller: slot state, tags, clock hand and result register.
module gwbc_dp #(
  parameter int SLOTS = gwbc_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gwbc_pkg::cmd_t                cmd,
  output gwbc_pkg::sts_t                sts,
  input  logic [gwbc_pkg::REQ_W-1:0]    in_req,
  input  logic [gwbc_pkg::ADDR_W-1:0]   in_addr,
  input  logic                          cfg_valid,
  input  logic [gwbc_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [gwbc_pkg::OUT_W-1:0]    out_tdata,
  output logic                          out_tlast
);
  import gwbc_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [EW-1:0] EMPTY_RST = EW'(SLOTS);

  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IW-1:0]     ptr_r;
  logic [IW-1:0]     hand_r;
  logic [IW-1:0]     slot_r;
  logic [EW-1:0]     empty_r;
  logic [CNT_W-1:0]  limit_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  dirty_r;
  logic [CNT_W-1:0]  cnt_r [SLOTS];
  logic [ADDR_W-1:0] tag_r [SLOTS];

  logic              out_valid_r;
  action_t           out_act_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ADDR_W-1:0] out_tgt_r;
  logic              out_last_r;

  logic [IW-1:0]     tag_idx;
  logic [ADDR_W-1:0] tag_rd;
  logic [IW-1:0]     cnt_idx;
  logic [CNT_W-1:0]  cnt_rd;
  logic [IW-1:0]     hand_adv;
  logic [IW-1:0]     emit_idx;
  logic              is_write;

  assign tag_idx  = cmd.use_slot ? slot_r : ptr_r;
  assign tag_rd   = tag_r[tag_idx];
  assign cnt_idx  = cmd.touch ? slot_r : hand_r;
  assign cnt_rd   = cnt_r[cnt_idx];
  assign hand_adv = (hand_r == LAST_IDX) ? '0 : hand_r + 1'b1;
  assign emit_idx = cmd.use_slot ? slot_r : ptr_r;
  assign is_write = (req_r == REQ_WRITE);

  always_comb begin
    sts.hit        = valid_r[ptr_r] && (tag_rd == addr_r);
    sts.ptr_last   = (ptr_r == LAST_IDX);
    sts.victim_ok  = !(valid_r[hand_r] && (cnt_rd != '0));
    sts.slot_dirty = dirty_r[slot_r];
    sts.flush_hit  = valid_r[ptr_r] && dirty_r[ptr_r];
    sts.out_free   = !out_valid_r || out_tready;
    sts.is_read    = (req_r == REQ_READ);
    sts.clr_wb     = (req_r == REQ_CLR_WB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      hand_r      <= '0;
      slot_r      <= '0;
      empty_r     <= EMPTY_RST;
      limit_r     <= LIMIT_RST;
      valid_r     <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.take_hit) begin
        slot_r <= ptr_r;
      end
      if (cmd.sweep) begin
        if (empty_r == '0) begin
          cnt_r[hand_r] <= cnt_rd - 1'b1;
        end
        hand_r <= hand_adv;
      end
      if (cmd.take_victim) begin
        slot_r <= hand_r;
        if (!valid_r[hand_r]) begin
          valid_r[hand_r] <= 1'b1;
          cnt_r[hand_r]   <= '0;
          if (empty_r != '0) begin
            empty_r <= empty_r - 1'b1;
          end
        end
      end
      if (cmd.install) begin
        dirty_r[slot_r] <= 1'b0;
      end
      if (cmd.touch) begin
        if (cnt_rd < limit_r) begin
          cnt_r[slot_r] <= cnt_rd + 1'b1;
        end
        if (is_write) begin
          dirty_r[slot_r] <= 1'b1;
        end
      end
      if (cmd.clear_all) begin
        valid_r <= '0;
        dirty_r <= '0;
        empty_r <= EMPTY_RST;
        for (int i = 0; i < SLOTS; i++) begin
          cnt_r[i] <= '0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req;
      addr_r <= in_addr;
    end
    if (cmd.install) begin
      tag_r[slot_r] <= addr_r;
    end
    if (cmd.emit) begin
      out_act_r  <= cmd.act;
      out_last_r <= cmd.last;
      unique case (cmd.act)
        ACT_DONE: begin
          out_slot_r <= '0;
          out_tgt_r  <= '0;
        end
        ACT_WB: begin
          out_slot_r <= SLOT_W'(emit_idx);
          out_tgt_r  <= tag_rd;
        end
        default: begin
          out_slot_r <= SLOT_W'(emit_idx);
          out_tgt_r  <= addr_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_tgt_r, out_slot_r, out_act_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/gclock_writeback_cache_ctrl_unit.sv
`timescale 1ns / 1ps
// Top level of the write-back cluster cache controller with clock replacement.
//
//  channel  direction  handshake             contents
//  in_      slave      in_tvalid/in_tready   tdata: req_type, cluster_address
//  out_     master     out_tvalid/out_tready tdata: action, slot, target_address; tlast
//  cfg_     slave      cfg_valid/cfg_ready   data: clock_limit
//
// Read/write hit: search from slot 0 up to the hit slot, then the serve result.
// Miss: search of all SLOTS slots, one hand step per cycle (up to 255 * SLOTS steps),
//   then take the victim, decide, and do write-back, fill and serve as needed.
// Flush: a pass through all slots, then the done result; clear adds a clear state.
// Reset clears valid, dirty and use counters, hand to 0, clock_limit to 3.
// A stalled result holds the output register; the sequencer waits where it has a result to emit.
module gclock_writeback_cache_ctrl_unit #(
  parameter int SLOTS = gwbc_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] req_type, [34:3] cluster_address, [39:35] zero
  input  logic [gwbc_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] action, [7:2] slot, [39:8] target_address
  output logic [gwbc_pkg::OUT_W-1:0]    out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gwbc_pkg::CNT_W-1:0]    cfg_data
);
  import gwbc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0] in_addr;

  assign in_req    = in_tdata[REQ_W-1:0];
  assign in_addr   = in_tdata[REQ_W +: ADDR_W];
  assign cfg_ready = 1'b1;

  gwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_req),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gwbc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_req),
    .in_addr    (in_addr),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/gwbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the cache controller, bound to the top level.
module gwbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [gwbc_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tlast
);
  import gwbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ACT_DONE) |-> out_tlast && (out_tdata[39:2] == '0))
    else $error("malformed done transaction");

  a_wb_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[1:0] == ACT_WB) || (out_tdata[1:0] == ACT_FILL)) |-> !out_tlast)
    else $error("write-back or fill marked last");

endmodule

bind gclock_writeback_cache_ctrl_unit gwbc_checker u_gwbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### dv/gclock_writeback_cache_ctrl_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clock-replacement write-back cache controller.
module gclock_writeback_cache_ctrl_unit_tb;
  import gwbc_pkg::*;

  localparam int LINES = SLOTS_DEF;
  localparam int SETTLE_CYCLES = 2 * LINES + 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POOL_SIZE = 20;
  localparam logic [REQ_W-1:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_LAST = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
  } cache_req_t;

  typedef struct packed {
    action_t           act;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] tgt;
    logic              last;
  } cache_cmd_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  cache_req_t req_backlog[$];
  cache_cmd_t exp_cmds[$];

  logic              line_valid [LINES];
  logic              line_dirty [LINES];
  logic [CNT_W-1:0]  line_cnt [LINES];
  logic [ADDR_W-1:0] line_tag [LINES];
  int unsigned       hand_pos;
  int unsigned       free_lines;
  logic [CNT_W-1:0]  use_limit;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic              idle_on;
  int unsigned       send_gap;
  int unsigned       recv_gap;
  int unsigned       quiet_cycles;
  int unsigned       mismatch_cnt;

  gclock_writeback_cache_ctrl_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void add_cmd(action_t a, int unsigned s, logic [ADDR_W-1:0] t);
    cache_cmd_t c;
    c.act = a;
    c.slot = s[SLOT_W-1:0];
    c.tgt = t;
    c.last = 1'b0;
    exp_cmds.push_back(c);
  endfunction

  function automatic void model_cache_access(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
    int unsigned idx;
    int unsigned h;
    int unsigned guard;
    idx = LINES;
    if (kind == REQ_READ || kind == REQ_WRITE) begin
      for (int unsigned i = 0; i < LINES; i++)
        if (idx == LINES && line_valid[i] && line_tag[i] == addr) idx = i;
      if (idx == LINES) begin
        h = hand_pos % LINES;
        guard = 0;
        while (line_valid[h] && line_cnt[h] != 0 && guard < LINES * 257) begin
          if (free_lines == 0) line_cnt[h] = line_cnt[h] - 1'b1;
          h = (h + 1) % LINES;
          guard++;
        end
        if (!line_valid[h]) begin
          if (free_lines > 0) free_lines--;
          line_valid[h] = 1'b1;
          line_cnt[h] = '0;
        end
        hand_pos = h;
        idx = h;
        if (line_dirty[idx]) add_cmd(ACT_WB, idx, line_tag[idx]);
        line_tag[idx] = addr;
        if (kind == REQ_READ) begin
          line_dirty[idx] = 1'b0;
          add_cmd(ACT_FILL, idx, addr);
        end
      end
      if (kind == REQ_WRITE) line_dirty[idx] = 1'b1;
      if (line_cnt[idx] < use_limit) line_cnt[idx] = line_cnt[idx] + 1'b1;
      add_cmd(ACT_SERVE, idx, addr);
    end else begin
      if (kind == REQ_FLUSH || kind == REQ_CLR_WB)
        for (int unsigned i = 0; i < LINES; i++)
          if (line_valid[i] && line_dirty[i]) add_cmd(ACT_WB, i, line_tag[i]);
      if (kind == REQ_CLR_WB || kind == REQ_CLR_DISCARD) begin
        for (int unsigned i = 0; i < LINES; i++) begin
          line_valid[i] = 1'b0;
          line_dirty[i] = 1'b0;
          line_cnt[i] = '0;
        end
        free_lines = LINES;
      end
      add_cmd(ACT_DONE, 0, '0);
    end
    exp_cmds[exp_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_req(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
    cache_req_t r;
    r.kind = kind;
    r.addr = addr;
    req_backlog.push_back(r);
  endfunction

  function automatic void queue_random_reqs(int unsigned n);
    int unsigned pick;
    logic [ADDR_W-1:0] a;
    for (int unsigned i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else a = $urandom;
      if (pick < 44) queue_req(REQ_READ, a);
      else if (pick < 88) queue_req(REQ_WRITE, a);
      else if (pick < 92) queue_req(REQ_FLUSH, a);
      else if (pick < 94) queue_req(REQ_CLR_WB, a);
      else if (pick < 96) queue_req(REQ_CLR_DISCARD, a);
      else queue_req(REQ_W'(REQ_BAD_FIRST
                            + $urandom_range(0, REQ_BAD_LAST - REQ_BAD_FIRST)), a);
    end
  endfunction

  function automatic void note_mismatch(string what, cache_cmd_t e, cache_cmd_t g);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: exp act=%0d slot=%0d tgt=%h last=%0b, got act=%0d slot=%0d tgt=%h last=%0b",
               $realtime, what, e.act, e.slot, e.tgt, e.last, g.act, g.slot, g.tgt, g.last);
  endfunction

  // request driver
  always @(posedge clk) begin
    cache_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) model_cache_access(in_tdata[2:0], in_tdata[34:3]);
      if (!in_tvalid || in_tready) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 13);
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          r = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, r.addr, r.kind};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cache_cmd_t got;
    cache_cmd_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.act = action_t'(out_tdata[1:0]);
        got.slot = out_tdata[7:2];
        got.tgt = out_tdata[39:8];
        got.last = out_tlast;
        if (exp_cmds.size() == 0) begin
          want = '0;
          note_mismatch("unexpected transaction", want, got);
        end else begin
          want = exp_cmds.pop_front();
          if (got !== want) note_mismatch("wrong transaction", want, got);
        end
      end
      if (recv_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
        recv_gap = $urandom_range(1, 13);
      if (recv_gap != 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gclock_writeback_cache_ctrl_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain_cache();
    while (req_backlog.size() != 0 || in_tvalid || exp_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    use_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] lim, int unsigned n);
    write_limit(lim);
    @(negedge clk);
    queue_random_reqs(n);
    drain_cache();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    mismatch_cnt = 0;
    for (int unsigned i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_cnt[i] = '0;
      line_tag[i] = '0;
    end
    hand_pos = 0;
    free_lines = LINES;
    use_limit = LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    queue_req(REQ_WRITE, 32'h0000_0000);
    queue_req(REQ_READ, 32'hFFFF_FFFF);
    queue_req(REQ_WRITE, 32'hFFFF_FFFF);
    queue_req(REQ_READ, 32'h0000_0000);
    for (int unsigned i = 1; i <= LINES - 2; i++) queue_req(REQ_WRITE, i);
    queue_req(REQ_WRITE, 32'h8000_0000);
    queue_req(REQ_READ, 32'h5555_5555);
    queue_req(REQ_FLUSH, 32'h0);
    queue_req(REQ_CLR_WB, 32'h0);
    queue_req(REQ_CLR_DISCARD, 32'h0);
    queue_req(REQ_BAD_FIRST, 32'hAAAA_AAAA);
    queue_req(REQ_BAD_LAST, 32'h0);
    drain_cache();

    run_phase(8'd255, 50);
    run_phase(8'd1, 50);
    run_phase(8'd0, 40);
    run_phase(CNT_W'($urandom_range(1, 254)), 50);
    run_phase(LIMIT_RST, 40);
    idle_on = 1'b0;
    run_phase(CNT_W'($urandom_range(1, 255)), 70);

    if (exp_cmds.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("gclock_writeback_cache_ctrl_unit: match");
    end else begin
      $display("gclock_writeback_cache_ctrl_unit: mismatch");
    end
    $finish;
  end

endmodule

### gclock_writeback_cache_ctrl_unit.f
rtl/gwbc_pkg.sv
rtl/gwbc_ctrl.sv
rtl/gwbc_dp.sv
rtl/gclock_writeback_cache_ctrl_unit.sv
rtl/gwbc_checker.sv
dv/gclock_writeback_cache_ctrl_unit_tb.sv
